### hdl/dio_pkg.sv
// Package for the DIO option parser: field codes, option types, status codes.
// No dependencies.
package dio_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 255;

	localparam logic [7:0] T_PAD1   = 8'd0;
	localparam logic [7:0] T_METRIC = 8'd2;
	localparam logic [7:0] T_ROUTE  = 8'd3;
	localparam logic [7:0] T_CONF   = 8'd4;
	localparam logic [7:0] T_PREFIX = 8'd8;
	localparam logic [7:0] MT_ENERGY = 8'd2;
	localparam logic [7:0] MT_ETX    = 8'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_UNHANDLED = 2'd2;

	localparam logic [5:0] F_INSTANCE = 6'd0;
	localparam logic [5:0] F_VERSION  = 6'd1;
	localparam logic [5:0] F_RANK     = 6'd2;
	localparam logic [5:0] F_GROUNDED = 6'd3;
	localparam logic [5:0] F_MOP      = 6'd4;
	localparam logic [5:0] F_PREF     = 6'd5;
	localparam logic [5:0] F_DTSN     = 6'd6;
	localparam logic [5:0] F_DODAGID  = 6'd7;
	localparam logic [5:0] F_MTYPE    = 6'd8;
	localparam logic [5:0] F_MFLAGS   = 6'd9;
	localparam logic [5:0] F_AGGR     = 6'd10;
	localparam logic [5:0] F_PREC     = 6'd11;
	localparam logic [5:0] F_MLEN     = 6'd12;
	localparam logic [5:0] F_ETX      = 6'd13;
	localparam logic [5:0] F_EFLAGS   = 6'd14;
	localparam logic [5:0] F_EEST     = 6'd15;
	localparam logic [5:0] F_RPLEN    = 6'd16;
	localparam logic [5:0] F_RFLAGS   = 6'd17;
	localparam logic [5:0] F_RLIFE    = 6'd18;
	localparam logic [5:0] F_RBYTE    = 6'd19;
	localparam logic [5:0] F_IDOUB    = 6'd20;
	localparam logic [5:0] F_IMIN     = 6'd21;
	localparam logic [5:0] F_REDUN    = 6'd22;
	localparam logic [5:0] F_MAXRANK  = 6'd23;
	localparam logic [5:0] F_MINHOP   = 6'd24;
	localparam logic [5:0] F_OCP      = 6'd25;
	localparam logic [5:0] F_DEFLIFE  = 6'd26;
	localparam logic [5:0] F_LUNIT    = 6'd27;
	localparam logic [5:0] F_PLEN     = 6'd28;
	localparam logic [5:0] F_PFLAGS   = 6'd29;
	localparam logic [5:0] F_PLIFE    = 6'd30;
	localparam logic [5:0] F_PBYTE    = 6'd31;
	localparam logic [5:0] F_STATUS   = 6'd32;

	localparam int unsigned MAX_RES = 5;
	localparam int unsigned QDEPTH = 4;

	typedef struct packed {
		logic [5:0]  code;
		logic [3:0]  idx;
		logic [31:0] val;
		logic        lastr;
	} rec_t;

	// Group of up to five records produced by one byte.
	typedef struct packed {
		logic [2:0]           cnt;
		rec_t [MAX_RES-1:0]   rec;
	} grp_t;

	typedef struct packed {
		logic [7:0] doublings;
		logic [7:0] imin;
		logic [7:0] redundancy;
	} dflt_t;

endpackage

### hdl/dio_front.sv
// Front part: per-byte parser state; turns each byte into a group of records.
// Depends on dio_pkg.
module dio_front #(
	parameter int unsigned MAX_MESSAGE_BYTES = dio_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  dio_pkg::dflt_t dflt,
	output dio_pkg::grp_t grp
);
	import dio_pkg::*;

	logic [7:0]  pos_q;
	logic [8:0]  off_q;
	logic [7:0]  otype_q;
	logic [8:0]  olen_q;
	logic [7:0]  mtype_q;
	logic [4:0]  pexp_q;
	logic [31:0] word_q;
	logic        cseen_q;
	logic [1:0]  err_q;

	logic [8:0]  off_n, olen_n;
	logic [7:0]  otype_n, mtype_n;
	logic [4:0]  pexp_n;
	logic        cseen_n;
	logic [1:0]  err_n;
	logic [31:0] w, wnew;
	logic [7:0]  b;
	logic        completes;
	logic [4:0]  nb;
	logic [8:0]  o;
	grp_t        g;

	function automatic rec_t mk(logic [5:0] c, logic [3:0] i, logic [31:0] v, logic l);
		rec_t r;
		r.code = c; r.idx = i; r.val = v; r.lastr = l;
		return r;
	endfunction

	always_comb begin
		b = data_byte;
		wnew = {word_q[23:0], b};
		// field decode sees the assembled word with the current byte shifted in
		w = wnew;
		o = off_q;
		off_n = off_q; olen_n = olen_q; otype_n = otype_q; mtype_n = mtype_q;
		pexp_n = pexp_q; cseen_n = cseen_q; err_n = err_q;
		g = '0;
		nb = 5'((9'(b) + 9'd7) >> 3);
		completes = (off_q <= 9'd1) ? (b == 8'd0) : (off_q + 9'd1 == olen_q);
		if (err_q == ST_OK) begin
			if (32'(pos_q) >= 32'(MAX_MESSAGE_BYTES)) begin
				err_n = ST_MALFORMED;
			end else if (pos_q < 8'd24) begin
				if (last_byte && pos_q < 8'd23) begin
					err_n = ST_MALFORMED;
				end else begin
					case (pos_q)
						8'd0: begin g.rec[0] = mk(F_INSTANCE, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1; end
						8'd1: begin g.rec[0] = mk(F_VERSION, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1; end
						8'd3: begin g.rec[0] = mk(F_RANK, 4'd0, {16'd0, wnew[15:0]}, 1'b0); g.cnt = 3'd1; end
						8'd4: begin
							g.rec[0] = mk(F_GROUNDED, 4'd0, 32'(b[7]), 1'b0);
							g.rec[1] = mk(F_MOP, 4'd0, 32'((b & 8'h3c) >> 3), 1'b0);
							g.rec[2] = mk(F_PREF, 4'd0, 32'(b & 8'h07), 1'b0);
							g.cnt = 3'd3;
						end
						8'd5: begin g.rec[0] = mk(F_DTSN, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1; end
						default: begin
							if (pos_q >= 8'd8) begin
								g.rec[0] = mk(F_DODAGID, 4'(pos_q - 8'd8), 32'(b), 1'b0);
								g.cnt = 3'd1;
							end
						end
					endcase
				end
			end else if (last_byte && !completes) begin
				err_n = ST_MALFORMED;
			end else if (o == 9'd0) begin
				otype_n = b;
				if (b != T_PAD1) off_n = 9'd1;
			end else begin
				if (o == 9'd1) begin
					olen_n = 9'd2 + 9'(b);
					if (otype_q == T_METRIC && olen_n < 9'd6) err_n = ST_MALFORMED;
					else if (otype_q == T_ROUTE && olen_n < 9'd9) err_n = ST_MALFORMED;
					else if (otype_q == T_CONF) begin
						if (olen_n != 9'd16) err_n = ST_MALFORMED; else cseen_n = 1'b1;
					end else if (otype_q == T_PREFIX && olen_n != 9'd32) err_n = ST_MALFORMED;
				end else begin
					case (otype_q)
						T_METRIC: begin
							if (o == 9'd2) begin
								if (b != MT_ETX && b != MT_ENERGY) err_n = ST_UNHANDLED;
								else if (olen_q < 9'd8) err_n = ST_MALFORMED;
								else begin
									mtype_n = b;
									g.rec[0] = mk(F_MTYPE, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
								end
							end else if (o == 9'd4) begin
								g.rec[0] = mk(F_MFLAGS, 4'd0, 32'({w[15:8], b[7]}), 1'b0);
								g.rec[1] = mk(F_AGGR, 4'd0, 32'(b[5:4]), 1'b0);
								g.rec[2] = mk(F_PREC, 4'd0, 32'(b[3:0]), 1'b0);
								g.cnt = 3'd3;
							end else if (o == 9'd5) begin
								g.rec[0] = mk(F_MLEN, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
							end else if (o == 9'd6 && mtype_q == MT_ENERGY) begin
								g.rec[0] = mk(F_EFLAGS, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
							end else if (o == 9'd7) begin
								if (mtype_q == MT_ETX)
									g.rec[0] = mk(F_ETX, 4'd0, {16'd0, wnew[15:0]}, 1'b0);
								else
									g.rec[0] = mk(F_EEST, 4'd0, 32'(b), 1'b0);
								g.cnt = 3'd1;
							end
						end
						T_ROUTE: begin
							if (o == 9'd2) begin
								if (b > 8'd128 || 9'(nb) + 9'd8 > olen_q) err_n = ST_MALFORMED;
								else begin
									pexp_n = nb;
									g.rec[0] = mk(F_RPLEN, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
								end
							end else if (o == 9'd3) begin
								g.rec[0] = mk(F_RFLAGS, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
							end else if (o == 9'd7) begin
								g.rec[0] = mk(F_RLIFE, 4'd0, wnew, 1'b0); g.cnt = 3'd1;
							end else if (o >= 9'd8 && (o - 9'd8) < 9'(pexp_q)) begin
								g.rec[0] = mk(F_RBYTE, 4'(o - 9'd8), 32'(b), 1'b0); g.cnt = 3'd1;
							end
						end
						T_CONF: begin
							g.cnt = 3'd1;
							case (o)
								9'd3:  g.rec[0] = mk(F_IDOUB, 4'd0, 32'(b), 1'b0);
								9'd4:  g.rec[0] = mk(F_IMIN, 4'd0, 32'(b), 1'b0);
								9'd5:  g.rec[0] = mk(F_REDUN, 4'd0, 32'(b), 1'b0);
								9'd7:  g.rec[0] = mk(F_MAXRANK, 4'd0, {16'd0, wnew[15:0]}, 1'b0);
								9'd9:  g.rec[0] = mk(F_MINHOP, 4'd0, {16'd0, wnew[15:0]}, 1'b0);
								9'd11: g.rec[0] = mk(F_OCP, 4'd0, {16'd0, wnew[15:0]}, 1'b0);
								9'd13: g.rec[0] = mk(F_DEFLIFE, 4'd0, 32'(b), 1'b0);
								9'd15: g.rec[0] = mk(F_LUNIT, 4'd0, {16'd0, wnew[15:0]}, 1'b0);
								default: g.cnt = 3'd0;
							endcase
						end
						T_PREFIX: begin
							if (o == 9'd2) begin
								g.rec[0] = mk(F_PLEN, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
							end else if (o == 9'd3) begin
								g.rec[0] = mk(F_PFLAGS, 4'd0, 32'(b), 1'b0); g.cnt = 3'd1;
							end else if (o == 9'd11) begin
								g.rec[0] = mk(F_PLIFE, 4'd0, wnew, 1'b0); g.cnt = 3'd1;
							end else if (o >= 9'd16 && o < 9'd32) begin
								g.rec[0] = mk(F_PBYTE, 4'(o - 9'd16), 32'(b), 1'b0); g.cnt = 3'd1;
							end
						end
						default: ;
					endcase
				end
				if (err_n == ST_OK)
					off_n = (o + 9'd1 == olen_n) ? 9'd0 : o + 9'd1;
			end
		end
		if (last_byte) begin
			if (err_n == ST_OK && off_n != 9'd0) err_n = ST_MALFORMED;
			if (!cseen_n) begin
				g.rec[g.cnt]         = mk(F_IDOUB, 4'd0, 32'(dflt.doublings), 1'b0);
				g.rec[g.cnt + 3'd1]  = mk(F_IMIN, 4'd0, 32'(dflt.imin), 1'b0);
				g.rec[g.cnt + 3'd2]  = mk(F_REDUN, 4'd0, 32'(dflt.redundancy), 1'b0);
				g.cnt = g.cnt + 3'd3;
			end
			g.rec[g.cnt] = mk(F_STATUS, 4'd0, 32'(err_n), 1'b1);
			g.cnt = g.cnt + 3'd1;
		end
		grp = g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; off_q <= '0; otype_q <= '0; olen_q <= '0; mtype_q <= '0;
			pexp_q <= '0; word_q <= '0; cseen_q <= 1'b0; err_q <= '0;
		end else if (en) begin
			if (last_byte) begin
				pos_q <= '0; off_q <= '0; otype_q <= '0; olen_q <= '0; mtype_q <= '0;
				pexp_q <= '0; word_q <= '0; cseen_q <= 1'b0; err_q <= '0;
			end else begin
				if (pos_q != 8'd255) pos_q <= pos_q + 8'd1;
				word_q <= wnew; off_q <= off_n; otype_q <= otype_n; olen_q <= olen_n;
				mtype_q <= mtype_n; pexp_q <= pexp_n; cseen_q <= cseen_n; err_q <= err_n;
			end
		end
	end

endmodule

### hdl/dio_back.sv
// Back part: queue of record groups, drained one record per pop.
// Depends on dio_pkg.
module dio_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  dio_pkg::grp_t  grp,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output dio_pkg::rec_t  rec
);
	import dio_pkg::*;

	localparam int unsigned AW = $clog2(QDEPTH);

	grp_t              mem_q [QDEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	logic [2:0]        sub_q;
	logic              do_wr, do_rd, grp_done;

	// Groups with no records are not stored.
	assign do_wr    = wr && (grp.cnt != 3'd0);
	assign full     = (cnt_q == (AW+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign rec      = mem_q[rp_q].rec[sub_q];
	assign grp_done = (sub_q + 3'd1 == mem_q[rp_q].cnt);
	assign do_rd    = pop && !empty && grp_done;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + AW'(1);
			if (pop && !empty) begin
				if (grp_done) begin
					rp_q <= rp_q + AW'(1);
					sub_q <= '0;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

endmodule

### hdl/dio_option_parser.sv
// Top level of the DIO option parser: config registers, front parser, result queue.
// Depends on dio_pkg, dio_front, dio_back.
//
// Usage:
//  - Input channel: push data_byte/last_byte while full is low; each
//    transaction is one payload byte of a DIO message, last_byte on the final.
//  - Result channel: while empty is low, field_code/byte_index/value/last_result
//    show the oldest record; pop it to advance. The status record carries
//    last_result = 1 and closes the message.
//  - Configuration: APB write at 0x0 / 0x4 / 0x8 sets the default interval
//    doublings, interval min and redundancy (reset 8, 12, 10); reads return them.
//  - Throughput: one byte per cycle while full is low. Each byte is parsed in its
//    accept cycle and its records (zero to five) land in a four-group queue.
//  - A byte's record group is registered into the queue as the byte is accepted.
//  - The back side drains one record per cycle while pop is high; a byte that
//    makes several records takes as many pops, so a stalled or slow reader fills
//    the queue and raises full, which holds the input until groups drain.
//  - Reset clears parser state and the queue; no clearing pass is needed.
module dio_option_parser #(
	parameter int unsigned MAX_MESSAGE_BYTES = dio_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	output logic [5:0]  field_code,
	output logic [3:0]  byte_index,
	output logic [31:0] value,
	output logic        last_result,
	output logic        empty,
	input  logic        pop,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dio_pkg::*;

	dflt_t dflt_q;
	grp_t  grp;
	rec_t  rec;
	logic  accept;

	assign pready = 1'b1;
	assign accept = push && !full;

	// Register file: word addresses 0..2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= '{doublings: 8'd8, imin: 8'd12, redundancy: 8'd10};
		end else if (psel && penable && pwrite) begin
			case (paddr)
				4'h0: dflt_q.doublings  <= pwdata[7:0];
				4'h4: dflt_q.imin       <= pwdata[7:0];
				4'h8: dflt_q.redundancy <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			4'h0: prdata = 32'(dflt_q.doublings);
			4'h4: prdata = 32'(dflt_q.imin);
			4'h8: prdata = 32'(dflt_q.redundancy);
			default: prdata = '0;
		endcase
	end

	dio_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .en(accept),
		.data_byte(data_byte), .last_byte(last_byte), .dflt(dflt_q), .grp(grp)
	);

	dio_back u_back (
		.clk(clk), .arst_n(arst_n), .wr(accept), .grp(grp),
		.full(full), .empty(empty), .pop(pop), .rec(rec)
	);

	assign field_code  = rec.code;
	assign byte_index  = rec.idx;
	assign value       = rec.val;
	assign last_result = rec.lastr;

endmodule

### hdl/dio_checker.sv
// Port-level checks for the DIO option parser, bound to the top level.
// Depends on dio_pkg and the dio_option_parser ports.
module dio_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [5:0]  field_code,
	input logic        last_result,
	input logic [31:0] value,
	input logic        pready
);
	import dio_pkg::*;

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last_result |-> field_code == F_STATUS) else $error("last without status");
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && field_code == F_STATUS |-> last_result && value <= 32'(ST_UNHANDLED))
		else $error("bad status record");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(value) && $stable(field_code))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind dio_option_parser dio_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.field_code(field_code), .last_result(last_result), .value(value), .pready(pready)
);

### bench/tb_dio_option_parser.sv
`timescale 1ns / 100ps
// Testbench for dio_option_parser: streams DIO payloads, predicts the field records
// in step with each accepted byte and checks them in order. Depends on dio_pkg.
module tb_dio_option_parser;
	import dio_pkg::*;

	localparam logic [3:0] REG_DOUBLINGS = 4'h0;
	localparam logic [3:0] REG_IMIN      = 4'h4;
	localparam logic [3:0] REG_REDUN     = 4'h8;
	localparam int STALL_LIMIT = 4000;
	localparam int HDR_BYTES   = 24;
	localparam int MSG_MAX     = 255;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [5:0]  field_code;
	logic [3:0]  byte_index;
	logic [31:0] value;
	logic        last_result;
	logic        empty;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	dio_option_parser u_top (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte), .last_byte(last_byte),
		.push(push), .full(full), .field_code(field_code), .byte_index(byte_index),
		.value(value), .last_result(last_result), .empty(empty), .pop(pop),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle percentages of the sender and of the receiver for the current phase.
	int send_idle = 0;
	int recv_idle = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// Records still owed by the parser, oldest first.
	rec_t pending_records[$];

	// Shadow copy of the parser: defaults and per-message state.
	logic [7:0]  dflt_doublings = 8'd8;
	logic [7:0]  dflt_imin = 8'd12;
	logic [7:0]  dflt_redun = 8'd10;
	int unsigned msg_pos, opt_off, opt_type, opt_len, metric_kind, route_bytes;
	logic [31:0] recent_bytes;
	bit          conf_taken;
	logic [1:0]  msg_status;
	int          rec_count;

	function automatic void clear_msg();
		msg_pos = 0; opt_off = 0; opt_type = 0; opt_len = 0; metric_kind = 0;
		route_bytes = 0; recent_bytes = '0; conf_taken = 0; msg_status = ST_OK;
	endfunction

	// Queue one record; a byte yields at most MAX_RES of them.
	function automatic void owe(logic [5:0] code, int unsigned bidx, logic [31:0] val,
			bit lastr = 0);
		rec_t r;
		if (rec_count >= MAX_RES)
			return;
		r.code = code;
		r.idx = bidx[3:0];
		r.val = val;
		r.lastr = lastr;
		pending_records.push_back(r);
		rec_count++;
	endfunction

	function automatic void decode_header(int unsigned p, logic [7:0] b);
		if (p == 0) owe(F_INSTANCE, 0, 32'(b));
		else if (p == 1) owe(F_VERSION, 0, 32'(b));
		else if (p == 3) owe(F_RANK, 0, 32'(recent_bytes[15:0]));
		else if (p == 4) begin
			owe(F_GROUNDED, 0, 32'(b[7]));
			owe(F_MOP, 0, 32'((b & 8'h3c) >> 3));
			owe(F_PREF, 0, 32'(b[2:0]));
		end else if (p == 5) owe(F_DTSN, 0, 32'(b));
		else if (p >= 8) owe(F_DODAGID, p - 8, 32'(b));
	endfunction

	function automatic void check_opt_len();
		if (opt_type == T_METRIC && opt_len < 6) msg_status = ST_MALFORMED;
		else if (opt_type == T_ROUTE && opt_len < 9) msg_status = ST_MALFORMED;
		else if (opt_type == T_CONF) begin
			if (opt_len != 16) msg_status = ST_MALFORMED;
			else conf_taken = 1;
		end else if (opt_type == T_PREFIX && opt_len != 32) msg_status = ST_MALFORMED;
	endfunction

	function automatic void decode_body(int unsigned o, logic [7:0] b);
		logic [31:0] w;
		int unsigned nb;
		w = recent_bytes;
		if (opt_type == T_METRIC) begin
			if (o == 2) begin
				if (b != MT_ETX && b != MT_ENERGY) msg_status = ST_UNHANDLED;
				else if (opt_len < 8) msg_status = ST_MALFORMED;
				else begin
					metric_kind = 32'(b);
					owe(F_MTYPE, 0, 32'(b));
				end
			end else if (o == 4) begin
				owe(F_MFLAGS, 0, 32'({w[15:8], b[7]}));
				owe(F_AGGR, 0, 32'(b[5:4]));
				owe(F_PREC, 0, 32'(b[3:0]));
			end else if (o == 5) owe(F_MLEN, 0, 32'(b));
			else if (o == 6 && metric_kind == MT_ENERGY) owe(F_EFLAGS, 0, 32'(b));
			else if (o == 7) begin
				if (metric_kind == MT_ETX) owe(F_ETX, 0, 32'(w[15:0]));
				else owe(F_EEST, 0, 32'(b));
			end
		end else if (opt_type == T_ROUTE) begin
			if (o == 2) begin
				nb = (32'(b) + 7) / 8;
				if (b > 128 || nb + 8 > opt_len) msg_status = ST_MALFORMED;
				else begin
					route_bytes = nb;
					owe(F_RPLEN, 0, 32'(b));
				end
			end else if (o == 3) owe(F_RFLAGS, 0, 32'(b));
			else if (o == 7) owe(F_RLIFE, 0, w);
			else if (o >= 8 && o - 8 < route_bytes) owe(F_RBYTE, o - 8, 32'(b));
		end else if (opt_type == T_CONF) begin
			if (o == 3) owe(F_IDOUB, 0, 32'(b));
			else if (o == 4) owe(F_IMIN, 0, 32'(b));
			else if (o == 5) owe(F_REDUN, 0, 32'(b));
			else if (o == 7) owe(F_MAXRANK, 0, 32'(w[15:0]));
			else if (o == 9) owe(F_MINHOP, 0, 32'(w[15:0]));
			else if (o == 11) owe(F_OCP, 0, 32'(w[15:0]));
			else if (o == 13) owe(F_DEFLIFE, 0, 32'(b));
			else if (o == 15) owe(F_LUNIT, 0, 32'(w[15:0]));
		end else if (opt_type == T_PREFIX) begin
			if (o == 2) owe(F_PLEN, 0, 32'(b));
			else if (o == 3) owe(F_PFLAGS, 0, 32'(b));
			else if (o == 11) owe(F_PLIFE, 0, w);
			else if (o >= 16 && o < 32) owe(F_PBYTE, o - 16, 32'(b));
		end
	endfunction

	function automatic void decode_option(logic [7:0] b);
		int unsigned o;
		o = opt_off;
		if (o == 0) begin
			opt_type = 32'(b);
			if (b != T_PAD1) opt_off = 1;
			return;
		end
		if (o == 1) begin
			opt_len = 32'(b) + 2;
			check_opt_len();
		end else
			decode_body(o, b);
		if (msg_status != ST_OK)
			return;
		opt_off = (o + 1 == opt_len) ? 0 : o + 1;
	endfunction

	// Work out the records that one accepted byte owes.
	function automatic void predict_byte(logic [7:0] b, bit last);
		int unsigned p;
		bit completes;
		p = msg_pos;
		rec_count = 0;
		if (msg_pos < 255) msg_pos++;
		recent_bytes = {recent_bytes[23:0], b};
		if (msg_status == ST_OK) begin
			if (p >= MSG_MAX) msg_status = ST_MALFORMED;
			else if (p < HDR_BYTES) begin
				if (last && p < HDR_BYTES - 1) msg_status = ST_MALFORMED;
				else decode_header(p, b);
			end else begin
				completes = (opt_off <= 1) ? (b == 0) : (opt_off + 1 == opt_len);
				if (last && !completes) msg_status = ST_MALFORMED;
				else decode_option(b);
			end
		end
		if (last) begin
			if (msg_status == ST_OK && opt_off != 0) msg_status = ST_MALFORMED;
			if (!conf_taken) begin
				owe(F_IDOUB, 0, 32'(dflt_doublings));
				owe(F_IMIN, 0, 32'(dflt_imin));
				owe(F_REDUN, 0, 32'(dflt_redun));
			end
			owe(F_STATUS, 0, 32'(msg_status), 1);
			clear_msg();
		end
	endfunction

	// Receiver: stall at random, check every popped record against the oldest one owed.
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
		if (arst_n && pop && !empty) begin
			if (pending_records.size() == 0) begin
				$error("unexpected record: code %0d value %0h", field_code, value);
				fail_count++;
			end else begin
				if (field_code !== pending_records[0].code) begin
					$error("field_code expected %0d got %0d",
						pending_records[0].code, field_code);
					fail_count++;
				end
				if (byte_index !== pending_records[0].idx) begin
					$error("byte_index expected %0d got %0d",
						pending_records[0].idx, byte_index);
					fail_count++;
				end
				if (value !== pending_records[0].val) begin
					$error("value expected %0h got %0h", pending_records[0].val, value);
					fail_count++;
				end
				if (last_result !== pending_records[0].lastr) begin
					$error("last_result expected %0b got %0b",
						pending_records[0].lastr, last_result);
					fail_count++;
				end
				void'(pending_records.pop_front());
			end
		end
	end

	// Watchdog: give up after a long stretch with no input, result or register transaction.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive one byte and hold it until the transaction completes. Push stays high
	// between back-to-back bytes; only an idle cycle drops it.
	task automatic send_byte(logic [7:0] b, bit last);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (full !== 1'b0);
		predict_byte(b, last);
	endtask

	task automatic send_msg(logic [7:0] msg[$]);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	// Drop push, wait until every owed record has been popped, then let the pipeline settle.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [3:0] addr, logic [7:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(data);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == REG_DOUBLINGS) dflt_doublings = data;
		else if (addr == REG_IMIN) dflt_imin = data;
		else dflt_redun = data;
	endtask

	// Message builders.
	function automatic void add_bytes(ref logic [7:0] m[$], input int n);
		repeat (n) m.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void add_header(ref logic [7:0] m[$]);
		add_bytes(m, HDR_BYTES);
	endfunction

	function automatic void add_conf(ref logic [7:0] m[$]);
		m.push_back(T_CONF); m.push_back(8'd14); add_bytes(m, 14);
	endfunction

	function automatic void add_prefix(ref logic [7:0] m[$]);
		m.push_back(T_PREFIX); m.push_back(8'd30); add_bytes(m, 30);
	endfunction

	function automatic void add_metric(ref logic [7:0] m[$], input logic [7:0] kind,
			input int len);
		m.push_back(T_METRIC); m.push_back(8'(len - 2)); m.push_back(kind);
		add_bytes(m, len - 3);
	endfunction

	function automatic void add_route(ref logic [7:0] m[$], input int len, input int plen);
		m.push_back(T_ROUTE); m.push_back(8'(len - 2)); m.push_back(8'(plen));
		add_bytes(m, len - 3);
	endfunction

	function automatic void add_random_option(ref logic [7:0] m[$]);
		int len;
		logic [7:0] t;
		case ($urandom_range(7))
			0: add_conf(m);
			1: add_prefix(m);
			2: begin
				len = $urandom_range(8, 20);
				case ($urandom_range(3))
					0: add_metric(m, MT_ENERGY, len);
					1: add_metric(m, 8'($urandom_range(255)), len);
					default: add_metric(m, MT_ETX, len);
				endcase
			end
			3: begin
				len = $urandom_range(9, 26);
				add_route(m, len, $urandom_range(0, ((len - 8) * 8 > 128) ? 128 : (len - 8) * 8));
			end
			4: m.push_back(T_PAD1);
			default: begin
				// PadN or a type the parser does not know: skipped by its length
				do t = 8'($urandom_range(255));
				while (t == T_PAD1 || t == T_METRIC || t == T_ROUTE || t == T_CONF ||
					t == T_PREFIX);
				len = $urandom_range(0, 6);
				m.push_back(t); m.push_back(8'(len)); add_bytes(m, len);
			end
		endcase
	endfunction

	function automatic void build_random_msg(ref logic [7:0] m[$]);
		int kind, n;
		kind = $urandom_range(9);
		m.delete();
		if (kind == 0) begin
			add_bytes(m, $urandom_range(1, 40));
			return;
		end
		add_header(m);
		n = $urandom_range(0, 4);
		repeat (n) if (m.size() < 190) add_random_option(m);
		if (kind == 1 && m.size() > 1) begin
			// broken: cut short or corrupt a byte
			if ($urandom_range(1)) m = m[0:$urandom_range(0, m.size() - 2)];
			else m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(255));
		end
	endfunction

	task automatic test_header_extremes();
		logic [7:0] m[$];
		m = {};
		repeat (HDR_BYTES) m.push_back(8'h00);
		send_msg(m);
		m = {};
		repeat (HDR_BYTES) m.push_back(8'hff);
		send_msg(m);
		drain();
	endtask

	task automatic test_options();
		logic [7:0] m[$];
		m = {}; add_header(m); add_conf(m); add_prefix(m); m.push_back(T_PAD1);
		send_msg(m);
		m = {}; add_header(m); add_metric(m, MT_ETX, 8); add_metric(m, MT_ENERGY, 10);
		m.push_back(8'd1); m.push_back(8'd2); add_bytes(m, 2);
		send_msg(m);
		m = {}; add_header(m); add_route(m, 24, 128); add_route(m, 9, 0);
		send_msg(m);
		drain();
	endtask

	task automatic test_errors();
		logic [7:0] m[$];
		// short base header
		m = {}; add_bytes(m, 10); send_msg(m);
		// truncated option
		m = {}; add_header(m); add_conf(m); m = m[0:m.size() - 4]; send_msg(m);
		// bad option lengths; the bytes after each length byte close the message
		m = {}; add_header(m); add_metric(m, MT_ETX, 5); send_msg(m);
		m = {}; add_header(m); add_route(m, 8, 0); send_msg(m);
		m = {}; add_header(m); m.push_back(T_CONF); m.push_back(8'd13); add_bytes(m, 1);
		send_msg(m);
		m = {}; add_header(m); m.push_back(T_PREFIX); m.push_back(8'd31); add_bytes(m, 1);
		send_msg(m);
		// unhandled metric type, and a handled one in a short option
		m = {}; add_header(m); add_metric(m, 8'd5, 10); send_msg(m);
		m = {}; add_header(m); add_metric(m, MT_ETX, 7); send_msg(m);
		// route prefix too long, or its bytes beyond the option
		m = {}; add_header(m); add_route(m, 10, 129); send_msg(m);
		m = {}; add_header(m); add_route(m, 9, 9); send_msg(m);
		// overlong message: the final byte lands one past the size limit
		m = {}; add_header(m); repeat (MSG_MAX + 1 - HDR_BYTES) m.push_back(T_PAD1);
		send_msg(m);
		drain();
	endtask

	task automatic test_config();
		logic [7:0] m[$];
		reg_write(REG_DOUBLINGS, 8'd0); reg_write(REG_IMIN, 8'd255); reg_write(REG_REDUN, 8'd0);
		m = {}; add_header(m); send_msg(m);
		drain();
		reg_write(REG_DOUBLINGS, 8'd255); reg_write(REG_IMIN, 8'd0);
		reg_write(REG_REDUN, 8'd255);
		m = {}; add_header(m); send_msg(m);
		drain();
	endtask

	task automatic test_random(int count, int s_idle, int r_idle);
		logic [7:0] m[$];
		int sent;
		send_idle = s_idle;
		recv_idle = r_idle;
		reg_write(REG_DOUBLINGS, 8'($urandom_range(255)));
		reg_write(REG_IMIN, 8'($urandom_range(255)));
		reg_write(REG_REDUN, 8'($urandom_range(255)));
		sent = 0;
		while (sent < count) begin
			build_random_msg(m);
			send_msg(m);
			sent += m.size();
		end
		drain();
	endtask

	initial begin
		clear_msg();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_extremes();
		test_options();
		test_errors();
		test_config();
		// the random part goes through every idling phase once
		test_random(30, 0, 0);
		test_random(30, 49, 0);
		test_random(30, 0, 49);
		test_random(30, 9, 9);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
hdl/dio_pkg.sv
hdl/dio_front.sv
hdl/dio_back.sv
hdl/dio_option_parser.sv
hdl/dio_checker.sv
bench/tb_dio_option_parser.sv
